// ----- src/pbu_pkg.sv -----
package pbu_pkg;

    typedef logic        [9:0]  idx_t;
    typedef logic        [14:0] pos_t;
    typedef logic signed [15:0] vel_t;
    typedef logic signed [12:0] accel_t;
    typedef logic signed [6:0]  kick_t;
    typedef logic        [7:0]  pix_t;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } cmd_t;

    typedef enum logic [0:0] {
        REG_LIMIT_X = 1'b0,
        REG_LIMIT_Y = 1'b1
    } reg_index_t;

    // input word, last field in the lowest bits
    typedef struct packed {
        vel_t   load_vel_y;
        vel_t   load_vel_x;
        pos_t   load_pos_y;
        pos_t   load_pos_x;
        kick_t  kick_y;
        kick_t  kick_x;
        accel_t accel_y;
        accel_t accel_x;
        idx_t   particle_index;
    } in_data_t;

    typedef struct packed {
        logic [5:0] pad;
        pix_t       pixel_y;
        pix_t       pixel_x;
        idx_t       result_index;
    } out_data_t;

    localparam int IN_DATA_W  = $bits(in_data_t);
    localparam int OUT_DATA_W = $bits(out_data_t);

    localparam pos_t LIMIT_X_RESET = 15'd12800;
    localparam pos_t LIMIT_Y_RESET = 15'd6400;
    localparam pos_t BOUNCE_MARGIN = 15'd100;
    localparam pos_t BOUNCE_FLOOR  = 15'd100;

    // p / 100 as p * 5243 >> 19, exact for p below 32768
    localparam logic [12:0] PIX_MUL   = 13'd5243;
    localparam int          PIX_SHIFT = 19;
    localparam logic [8:0]  PIX_MAX   = 9'd255;

    function automatic pix_t pixel_of(input pos_t p);
        logic [27:0] prod;
        logic [8:0]  q;
        prod = 28'(p) * 28'(PIX_MUL);
        q    = prod[PIX_SHIFT +: 9];
        return (q > PIX_MAX) ? PIX_MAX[7:0] : q[7:0];
    endfunction

endpackage

// ----- src/pbu_ram.sv -----
module pbu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/pbu_axis.sv -----
module pbu_axis (
    input  pbu_pkg::pos_t   pos,
    input  pbu_pkg::vel_t   vel,
    input  pbu_pkg::accel_t accel,
    input  pbu_pkg::kick_t  kick,
    input  pbu_pkg::pos_t   limit,
    output pbu_pkg::pos_t   pos_new,
    output pbu_pkg::vel_t   vel_new
);

    logic signed [16:0] vsum;
    logic signed [15:0] vs;
    logic signed [17:0] p;
    logic signed [16:0] w;
    logic signed [16:0] half;
    logic signed [17:0] kicked;
    logic signed [15:0] vb;
    pbu_pkg::pos_t      top;
    logic               hit_high;
    logic               hit_low;

    always_comb begin
        vsum = {vel[15], vel} + {{4{accel[12]}}, accel};
        if (vsum[16] != vsum[15]) begin
            vs = vsum[16] ? 16'sh8000 : 16'sh7fff;
        end else begin
            vs = vsum[15:0];
        end

        p = $signed({3'b000, pos}) + {{2{vs[15]}}, vs};

        top      = (limit < pbu_pkg::BOUNCE_MARGIN) ? '0 : limit - pbu_pkg::BOUNCE_MARGIN;
        hit_high = p > $signed({3'b000, limit});
        hit_low  = p[17];

        // one step toward zero, zero goes to -1
        w = vs[15] ? ({vs[15], vs} + 17'sd1) : ({vs[15], vs} - 17'sd1);
        // -w/2 with truncation toward zero
        half   = w[16] ? ((-w) >>> 1) : -(w >>> 1);
        kicked = {half[16], half} + {{11{kick[6]}}, kick};
        if (kicked[17:15] != 3'b000 && kicked[17:15] != 3'b111) begin
            vb = kicked[17] ? 16'sh8000 : 16'sh7fff;
        end else begin
            vb = kicked[15:0];
        end

        if (hit_high) begin
            pos_new = top;
            vel_new = vb;
        end else if (hit_low) begin
            pos_new = pbu_pkg::BOUNCE_FLOOR;
            vel_new = vb;
        end else begin
            pos_new = p[14:0];
            vel_new = vs;
        end
    end

endmodule

// ----- src/particle_bounce_update.sv -----
// Particle bounce updater.
// Input words arrive on s_t*: tuser is the command (load or step), tdata the
// particle index, accelerations, kicks and load values. Every word yields one
// result word on m_t* with the index and its pixel (position / 100, max 255).
// Limits are written through cfg_*, only while the block is idle; the user
// must keep to this, as the block has no check for it. Position and
// velocity live in two RAMs with a registered read. A word is accepted, its
// entry is read, and then both axes are stepped or loaded, written back and
// registered into the output stage once it is free; m_tvalid rises as the
// word enters it. One word is taken every cycle while the receiver is ready.
// That rate rests on the single update stage: the write-back of one word
// is forwarded to the next word when both address the same particle.
// When the receiver stalls, the result waits in the output register, one
// more word waits in the update stage and then s_tready drops.
// Reset clears the pipeline and loads the default limits; the RAMs are not
// cleared, so a particle must be loaded before it is stepped.
// An index at or above PARTICLES changes nothing and reports pixel zero.
module particle_bounce_update #(
    parameter int PARTICLES = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // particle_index, accel_x, accel_y, kick_x, kick_y, load_pos_x,
    // load_pos_y, load_vel_x, load_vel_y
    input  logic [pbu_pkg::IN_DATA_W-1:0]  s_tdata,
    // command
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result_index, pixel_x, pixel_y, zero fill
    output logic [pbu_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [0:0]                     cfg_index,
    input  logic [14:0]                    cfg_data
);

    localparam int          ADDR_W = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam logic [12:0] PART_N = 13'(PARTICLES);

    pbu_pkg::in_data_t  in_d;
    pbu_pkg::out_data_t out_d;

    logic s_accept;
    logic s1_adv;
    logic wr_en;

    logic               s1_valid_reg;
    logic               m_valid_reg;
    pbu_pkg::pos_t      limit_x_reg;
    pbu_pkg::pos_t      limit_y_reg;

    pbu_pkg::cmd_t      s1_cmd_reg;
    pbu_pkg::in_data_t  s1_d_reg;
    logic               s1_in_range_reg;
    logic               s1_fwd_reg;
    logic [29:0]        last_wpos_reg;
    logic [31:0]        last_wvel_reg;
    pbu_pkg::idx_t      m_index_reg;
    pbu_pkg::pos_t      m_pos_x_reg;
    pbu_pkg::pos_t      m_pos_y_reg;

    logic [29:0]        pos_rdata;
    logic [31:0]        vel_rdata;
    logic [29:0]        cur_pos;
    logic [31:0]        cur_vel;
    pbu_pkg::pos_t      step_pos_x;
    pbu_pkg::pos_t      step_pos_y;
    pbu_pkg::vel_t      step_vel_x;
    pbu_pkg::vel_t      step_vel_y;
    logic [29:0]        new_pos;
    logic [31:0]        new_vel;
    logic               in_range;

    assign in_d      = s_tdata;
    assign cfg_ready = 1'b1;

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;
    assign wr_en    = s1_adv && s1_in_range_reg;
    assign in_range = {3'b000, in_d.particle_index} < PART_N;

    pbu_ram #(.WIDTH(30), .DEPTH(PARTICLES)) u_pos_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (ADDR_W'(s1_d_reg.particle_index)),
        .wdata (new_pos),
        .re    (s_accept),
        .raddr (ADDR_W'(in_d.particle_index)),
        .rdata (pos_rdata)
    );

    pbu_ram #(.WIDTH(32), .DEPTH(PARTICLES)) u_vel_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (ADDR_W'(s1_d_reg.particle_index)),
        .wdata (new_vel),
        .re    (s_accept),
        .raddr (ADDR_W'(in_d.particle_index)),
        .rdata (vel_rdata)
    );

    // write-back at the read edge is not seen by the ram read
    assign cur_pos = s1_fwd_reg ? last_wpos_reg : pos_rdata;
    assign cur_vel = s1_fwd_reg ? last_wvel_reg : vel_rdata;

    pbu_axis u_axis_x (
        .pos     (cur_pos[14:0]),
        .vel     (cur_vel[15:0]),
        .accel   (s1_d_reg.accel_x),
        .kick    (s1_d_reg.kick_x),
        .limit   (limit_x_reg),
        .pos_new (step_pos_x),
        .vel_new (step_vel_x)
    );

    pbu_axis u_axis_y (
        .pos     (cur_pos[29:15]),
        .vel     (cur_vel[31:16]),
        .accel   (s1_d_reg.accel_y),
        .kick    (s1_d_reg.kick_y),
        .limit   (limit_y_reg),
        .pos_new (step_pos_y),
        .vel_new (step_vel_y)
    );

    always_comb begin
        if (s1_cmd_reg == pbu_pkg::CMD_LOAD) begin
            new_pos = {s1_d_reg.load_pos_y, s1_d_reg.load_pos_x};
            new_vel = {s1_d_reg.load_vel_y, s1_d_reg.load_vel_x};
        end else begin
            new_pos = {step_pos_y, step_pos_x};
            new_vel = {step_vel_y, step_vel_x};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            limit_x_reg  <= pbu_pkg::LIMIT_X_RESET;
            limit_y_reg  <= pbu_pkg::LIMIT_Y_RESET;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (pbu_pkg::reg_index_t'(cfg_index))
                    pbu_pkg::REG_LIMIT_X: limit_x_reg <= cfg_data;
                    pbu_pkg::REG_LIMIT_Y: limit_y_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cmd_reg      <= pbu_pkg::cmd_t'(s_tuser);
            s1_d_reg        <= in_d;
            s1_in_range_reg <= in_range;
            s1_fwd_reg      <= wr_en && (s1_d_reg.particle_index == in_d.particle_index);
        end
        if (wr_en) begin
            last_wpos_reg <= new_pos;
            last_wvel_reg <= new_vel;
        end
        if (s1_adv) begin
            m_index_reg <= s1_d_reg.particle_index;
            m_pos_x_reg <= s1_in_range_reg ? new_pos[14:0]  : '0;
            m_pos_y_reg <= s1_in_range_reg ? new_pos[29:15] : '0;
        end
    end

    always_comb begin
        out_d.pad          = '0;
        out_d.result_index = m_index_reg;
        out_d.pixel_x      = pbu_pkg::pixel_of(m_pos_x_reg);
        out_d.pixel_y      = pbu_pkg::pixel_of(m_pos_y_reg);
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_d;

endmodule

// ----- src/pbu_checker.sv -----
module pbu_checker #(
    parameter int PARTICLES = 1024
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [pbu_pkg::IN_DATA_W-1:0]  s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [pbu_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam logic [12:0] PART_N = 13'(PARTICLES);

    pbu_pkg::out_data_t out_d;
    assign out_d = m_tdata;

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word changed while stalled");

    // a ready receiver sees the word after the output register, in order
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready |=>
            m_tvalid && (out_d.result_index == $past(s_tdata[9:0], 2)))
        else $error("result word late or out of order");

    a_out_of_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ({3'b000, out_d.result_index} >= PART_N) |->
            (out_d.pixel_x == 8'd0) && (out_d.pixel_y == 8'd0))
        else $error("absent particle reported a nonzero pixel");

endmodule

bind particle_bounce_update pbu_checker #(.PARTICLES(PARTICLES)) u_pbu_checker (.*);
